### rtl/esd_pkg.sv
// Shared types, character codes and escape tables of the escape sequence decoder.
`default_nettype none

package esd_pkg;

  // Field widths.
  localparam int unsigned CHAR_W = 16;
  localparam int unsigned CNT_W = 4;
  localparam int unsigned SYM_W = 7;
  localparam int unsigned DIGIT_W = 8;
  localparam int unsigned BASE_W = 5;

  // Largest digit count that any escape kind asks for.
  localparam int unsigned SIZE_LIMIT = 8;

  // Entries in the command queue between parser and emitter.
  localparam int unsigned CMD_DEPTH = 2;

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_BSL = 16'h005C;
  localparam logic [CHAR_W-1:0] CH_LF = 16'h000A;
  localparam logic [CHAR_W-1:0] CH_TAB = 16'h0009;
  localparam logic [CHAR_W-1:0] CH_CR = 16'h000D;
  localparam logic [CHAR_W-1:0] CH_NUL = 16'h0000;
  localparam logic [CHAR_W-1:0] CH_ZERO = 16'h0030;
  localparam logic [CHAR_W-1:0] CH_NINE = 16'h0039;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 16'h0041;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 16'h005A;
  localparam logic [CHAR_W-1:0] CH_LOW_B = 16'h0062;
  localparam logic [CHAR_W-1:0] CH_LOW_D = 16'h0064;
  localparam logic [CHAR_W-1:0] CH_LOW_N = 16'h006E;
  localparam logic [CHAR_W-1:0] CH_LOW_O = 16'h006F;
  localparam logic [CHAR_W-1:0] CH_LOW_R = 16'h0072;
  localparam logic [CHAR_W-1:0] CH_LOW_T = 16'h0074;
  localparam logic [CHAR_W-1:0] CH_LOW_U = 16'h0075;
  localparam logic [CHAR_W-1:0] CH_LOW_X = 16'h0078;
  localparam logic [CHAR_W-1:0] CASE_MASK = 16'h00DF;
  localparam logic [CHAR_W-1:0] LETTER_OFFSET = 16'd10;

  // Digit value that marks a character which is no digit at all.
  localparam logic [DIGIT_W-1:0] DIGIT_NONE = 8'hFF;

  // Numeric escape kinds.
  typedef enum logic [2:0] {
    KIND_BIN,
    KIND_OCT,
    KIND_DEC,
    KIND_HEX2,
    KIND_HEX4
  } esd_kind_e;

  // One unit of work handed from the parser to the emitter.
  typedef struct packed {
    logic              flush;       // emit backslash, letter and buffered digits
    logic [CHAR_W-1:0] letter;
    logic [CNT_W-1:0]  count;       // buffered digits to emit
    logic              tail_valid;  // one more character follows
    logic [CHAR_W-1:0] tail;
    logic              last;        // request ends the query
  } esd_cmd_t;

  // Number of digits an escape kind takes.
  function automatic logic [CNT_W-1:0] kind_size(esd_kind_e kind);
    logic [CNT_W-1:0] size;
    unique case (kind)
      KIND_BIN: size = 4'd8;
      KIND_OCT: size = 4'd3;
      KIND_DEC: size = 4'd3;
      KIND_HEX2: size = 4'd2;
      default: size = 4'd4;
    endcase
    return size;
  endfunction

  // Radix of an escape kind.
  function automatic logic [BASE_W-1:0] kind_base(esd_kind_e kind);
    logic [BASE_W-1:0] base;
    unique case (kind)
      KIND_BIN: base = 5'd2;
      KIND_OCT: base = 5'd8;
      KIND_DEC: base = 5'd10;
      default: base = 5'd16;
    endcase
    return base;
  endfunction

  // Letter that opened an escape kind.
  function automatic logic [CHAR_W-1:0] kind_letter(esd_kind_e kind);
    logic [CHAR_W-1:0] letter;
    unique case (kind)
      KIND_BIN: letter = CH_LOW_B;
      KIND_OCT: letter = CH_LOW_O;
      KIND_DEC: letter = CH_LOW_D;
      KIND_HEX2: letter = CH_LOW_X;
      default: letter = CH_LOW_U;
    endcase
    return letter;
  endfunction

  // Value of a digit character in any radix up to 36; DIGIT_NONE otherwise.
  function automatic logic [DIGIT_W-1:0] digit_of(logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] u;
    logic [DIGIT_W-1:0] d;
    u = c & CASE_MASK;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = DIGIT_W'(c - CH_ZERO);
    end else if (u >= CH_UPPER_A && u <= CH_UPPER_Z) begin
      d = DIGIT_W'(u - CH_UPPER_A + LETTER_OFFSET);
    end else begin
      d = DIGIT_NONE;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

### rtl/esd_if.sv
// Stream interfaces for the input characters and the decoded characters.
`default_nettype none

interface esd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] char_in;
  logic        is_final;

  modport source(output valid, output char_in, output is_final, input ready);
  modport sink(input valid, input char_in, input is_final, output ready);
endinterface

interface esd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] char_out;
  logic        is_final_out;

  modport source(output valid, output char_out, output is_final_out, input ready);
  modport sink(input valid, input char_out, input is_final_out, output ready);
endinterface

`default_nettype wire

### rtl/esd_cmd_fifo.sv
// Small command queue that decouples the parser from the emitter.
`default_nettype none

module esd_cmd_fifo
  import esd_pkg::*;
#(
  parameter int unsigned WIDTH = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PTR_W = $clog2(CMD_DEPTH);
  localparam int unsigned CNT_BITS = $clog2(CMD_DEPTH + 1);

  logic [WIDTH-1:0]    mem_q [CMD_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;

  assign full_o = (cnt_q == CNT_BITS'(CMD_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o = mem_q[rd_ptr_q];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/esd_front.sv
// Parser: accepts input characters, tracks the escape state and issues emit commands.
`default_nettype none

module esd_front
  import esd_pkg::*;
#(
  parameter int unsigned DIG_USED = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  esd_in_if.sink                         in_i,
  input  logic                           full_i,
  output logic                           push_o,
  output esd_cmd_t                       cmd_o,
  output logic [DIG_USED-1:0][SYM_W-1:0] digits_o
);

  localparam int unsigned IDX_W = $clog2(DIG_USED);

  typedef enum logic [1:0] {
    PH_TEXT,
    PH_ESC,
    PH_DIG
  } phase_e;

  phase_e                         phase_q, phase_d;
  esd_kind_e                      kind_q, kind_d, new_kind;
  logic [CNT_W-1:0]               taken_q, taken_d, taken_inc;
  logic [CHAR_W-1:0]              acc_q, acc_d, scaled;
  logic [DIG_USED-1:0][SYM_W-1:0] buf_q, buf_d;

  logic              accept;
  logic              start;
  logic [CHAR_W-1:0] c;
  logic              fin;
  logic [DIGIT_W-1:0] digit;
  logic [CNT_W-1:0]  size;
  logic [CNT_W-1:0]  needed;

  assign in_i.ready = !full_i;
  assign accept = in_i.valid && !full_i;
  assign c = in_i.char_in;
  assign fin = in_i.is_final;
  assign digit = digit_of(c);
  assign size = kind_size(kind_q);
  assign needed = (size > CNT_W'(DIG_USED)) ? CNT_W'(DIG_USED) : size;
  assign taken_inc = taken_q + 1'b1;
  assign digits_o = buf_d;

  // Accumulator times the radix, built from shifts.
  always_comb begin
    unique case (kind_q)
      KIND_BIN: scaled = acc_q << 1;
      KIND_OCT: scaled = acc_q << 3;
      KIND_DEC: scaled = (acc_q << 3) + (acc_q << 1);
      default: scaled = acc_q << 4;
    endcase
  end

  // Parse one accepted character.
  always_comb begin
    phase_d = phase_q;
    kind_d = kind_q;
    taken_d = taken_q;
    acc_d = acc_q;
    buf_d = buf_q;
    push_o = 1'b0;
    cmd_o = '0;
    cmd_o.last = fin;
    start = 1'b0;
    new_kind = KIND_BIN;
    if (accept) begin
      unique case (phase_q)
        PH_ESC: begin
          phase_d = PH_TEXT;
          unique case (c)
            CH_LOW_N: begin
              push_o = 1'b1;
              cmd_o.tail_valid = 1'b1;
              cmd_o.tail = CH_LF;
            end
            CH_LOW_T: begin
              push_o = 1'b1;
              cmd_o.tail_valid = 1'b1;
              cmd_o.tail = CH_TAB;
            end
            CH_LOW_R: begin
              push_o = 1'b1;
              cmd_o.tail_valid = 1'b1;
              cmd_o.tail = CH_CR;
            end
            CH_ZERO: begin
              push_o = 1'b1;
              cmd_o.tail_valid = 1'b1;
              cmd_o.tail = CH_NUL;
            end
            CH_BSL: begin
              push_o = 1'b1;
              cmd_o.tail_valid = 1'b1;
              cmd_o.tail = CH_BSL;
            end
            CH_LOW_B: begin
              start = 1'b1;
              new_kind = KIND_BIN;
            end
            CH_LOW_O: begin
              start = 1'b1;
              new_kind = KIND_OCT;
            end
            CH_LOW_D: begin
              start = 1'b1;
              new_kind = KIND_DEC;
            end
            CH_LOW_X: begin
              start = 1'b1;
              new_kind = KIND_HEX2;
            end
            CH_LOW_U: begin
              start = 1'b1;
              new_kind = KIND_HEX4;
            end
            default: begin
              // Unknown escape: backslash and the character itself.
              push_o = 1'b1;
              cmd_o.flush = 1'b1;
              cmd_o.letter = c;
            end
          endcase
          // A digit escape opens; if the query ends here it falls back.
          if (start) begin
            kind_d = new_kind;
            taken_d = '0;
            acc_d = '0;
            if (fin) begin
              push_o = 1'b1;
              cmd_o.flush = 1'b1;
              cmd_o.letter = kind_letter(new_kind);
            end else begin
              phase_d = PH_DIG;
            end
          end
        end
        PH_DIG: begin
          if (digit < DIGIT_W'(kind_base(kind_q)) && taken_q < needed) begin
            acc_d = scaled + CHAR_W'(digit);
            buf_d[taken_q[IDX_W-1:0]] = c[SYM_W-1:0];
            taken_d = taken_inc;
            if (taken_inc >= needed) begin
              push_o = 1'b1;
              cmd_o.tail_valid = 1'b1;
              cmd_o.tail = acc_d;
              phase_d = PH_TEXT;
            end else if (fin) begin
              push_o = 1'b1;
              cmd_o.flush = 1'b1;
              cmd_o.letter = kind_letter(kind_q);
              cmd_o.count = taken_inc;
              phase_d = PH_TEXT;
            end
          end else begin
            // Fallback, then the offending character is read as text.
            push_o = 1'b1;
            cmd_o.flush = 1'b1;
            cmd_o.letter = kind_letter(kind_q);
            cmd_o.count = taken_q;
            if (c == CH_BSL && !fin) begin
              phase_d = PH_ESC;
            end else begin
              phase_d = PH_TEXT;
              cmd_o.tail_valid = 1'b1;
              cmd_o.tail = c;
            end
          end
        end
        default: begin
          if (c == CH_BSL && !fin) begin
            phase_d = PH_ESC;
          end else begin
            phase_d = PH_TEXT;
            push_o = 1'b1;
            cmd_o.tail_valid = 1'b1;
            cmd_o.tail = c;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TEXT;
      kind_q <= KIND_BIN;
      taken_q <= '0;
      acc_q <= '0;
    end else begin
      phase_q <= phase_d;
      kind_q <= kind_d;
      taken_q <= taken_d;
      acc_q <= acc_d;
    end
  end

  // Digit buffer is only read after it has been written for the current escape.
  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule

`default_nettype wire

### rtl/esd_back.sv
// Emitter: expands each command into output characters through a registered output stage.
`default_nettype none

module esd_back
  import esd_pkg::*;
#(
  parameter int unsigned DIG_USED = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           avail_i,
  input  esd_cmd_t                       cmd_i,
  input  logic [DIG_USED-1:0][SYM_W-1:0] digits_i,
  output logic                           pop_o,
  esd_out_if.source                      out_o
);

  localparam int unsigned DIG_W = $clog2(DIG_USED);

  typedef enum logic [1:0] {
    ST_BSL,
    ST_LET,
    ST_DIG,
    ST_TAIL
  } step_e;

  step_e             step_q, cur_step, nxt_step;
  logic [DIG_W-1:0]  dig_q, cur_dig, nxt_dig;
  logic              started_q;
  logic              valid_q;
  logic [CHAR_W-1:0] char_q, cur_char;
  logic              last_q;
  logic              load;
  logic              is_last;
  logic              dig_end;

  assign out_o.valid = valid_q;
  assign out_o.char_out = char_q;
  assign out_o.is_final_out = last_q;

  // Where in the current command the emitter stands.
  assign cur_step = started_q ? step_q : (cmd_i.flush ? ST_BSL : ST_TAIL);
  assign cur_dig = started_q ? dig_q : '0;
  assign dig_end = ((CNT_W + 1)'(cur_dig) + (CNT_W + 1)'(1)) == {1'b0, cmd_i.count};

  // Character of the current step and the step after it.
  always_comb begin
    nxt_dig = cur_dig + 1'b1;
    unique case (cur_step)
      ST_BSL: begin
        cur_char = CH_BSL;
        nxt_step = ST_LET;
        is_last = 1'b0;
      end
      ST_LET: begin
        cur_char = cmd_i.letter;
        nxt_step = (cmd_i.count != '0) ? ST_DIG : ST_TAIL;
        nxt_dig = '0;
        is_last = (cmd_i.count == '0) && !cmd_i.tail_valid;
      end
      ST_DIG: begin
        cur_char = CHAR_W'(digits_i[cur_dig]);
        nxt_step = dig_end ? ST_TAIL : ST_DIG;
        is_last = dig_end && !cmd_i.tail_valid;
      end
      ST_TAIL: begin
        cur_char = cmd_i.tail;
        nxt_step = ST_TAIL;
        is_last = 1'b1;
      end
    endcase
  end

  assign load = avail_i && (!valid_q || out_o.ready);
  assign pop_o = load && is_last;

  // Step sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_BSL;
      dig_q <= '0;
      started_q <= 1'b0;
      valid_q <= 1'b0;
      char_q <= '0;
      last_q <= 1'b0;
    end else if (load) begin
      step_q <= nxt_step;
      dig_q <= nxt_dig;
      started_q <= !is_last;
      valid_q <= 1'b1;
      char_q <= cur_char;
      last_q <= cmd_i.last && is_last;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### rtl/escape_sequence_decoder.sv
// Top level of the streaming backslash escape decoder.
// Takes one 16-bit character per cycle while the queue has room and returns the decoded
// characters one per cycle while the output is ready. The parser decides for each input
// character what to emit and places that request in a two-entry queue; the emitter
// expands each request into characters. A plain character or a complete escape yields
// one output character, so the stream runs at one character per cycle unless stalled. A
// fallback (invalid digit, early end of query or unknown escape) yields the backslash,
// the letter, the digits taken and possibly the offending character: up to ten output
// characters, sent one after another through the emitter's single output port, and
// input stalls once the queue is full. An escape prefix or a digit that does not yet
// complete an escape yields nothing. There is no clearing pass after reset.
`default_nettype none

module escape_sequence_decoder
  import esd_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  esd_in_if.sink    in_i,
  esd_out_if.source out_o
);

  // Digits beyond the longest escape are never stored.
  localparam int unsigned DIG_USED = (MAX_DIGITS < SIZE_LIMIT) ? MAX_DIGITS : SIZE_LIMIT;
  localparam int unsigned CMD_W = $bits(esd_cmd_t) + DIG_USED * SYM_W;

  logic                           push;
  logic                           full;
  logic                           pop;
  logic                           empty;
  esd_cmd_t                       cmd_f, cmd_b;
  logic [DIG_USED-1:0][SYM_W-1:0] digits_f, digits_b;
  logic [CMD_W-1:0]               fifo_in, fifo_out;

  esd_front #(
    .DIG_USED(DIG_USED)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .cmd_o   (cmd_f),
    .digits_o(digits_f)
  );

  assign fifo_in = {cmd_f, digits_f};

  esd_cmd_fifo #(
    .WIDTH(CMD_W)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (fifo_in),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (fifo_out)
  );

  assign {cmd_b, digits_b} = fifo_out;

  esd_back #(
    .DIG_USED(DIG_USED)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (!empty),
    .cmd_i   (cmd_b),
    .digits_i(digits_b),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench of the escape sequence decoder with random stimulus and stalls.
`timescale 1ns / 100ps

module tb_top
  import esd_pkg::*;
();

  localparam int unsigned ESC_DIGITS = 8;
  localparam int unsigned DIG_IDX_W = $clog2(ESC_DIGITS);
  localparam int unsigned TOTAL_ITEMS = 360;
  localparam int unsigned QUIET_TAIL = 40;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef enum logic [1:0] {
    PH_TEXT,
    PH_ESCAPE,
    PH_DIGITS
  } parse_phase_e;

  // One character of a query, on either side of the block.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              fin;
  } text_char_t;

  logic clk;
  logic rst_n;

  esd_in_if  in_if ();
  esd_out_if out_if ();

  escape_sequence_decoder #(
    .MAX_DIGITS(ESC_DIGITS)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  text_char_t        pending_chars[$];
  text_char_t        expected_chars[$];
  logic [CHAR_W-1:0] query_buf[$];
  logic [CHAR_W-1:0] burst_chars[$];

  // Decoder state as predicted by the testbench.
  parse_phase_e      phase_q = PH_TEXT;
  esd_kind_e         kind_q = KIND_BIN;
  logic [CNT_W-1:0]  taken_q = '0;
  logic [CHAR_W-1:0] acc_q = '0;
  logic [SYM_W-1:0]  digits_q[ESC_DIGITS];

  int unsigned total_items;
  int unsigned accepted_count = 0;
  int unsigned checked_count = 0;
  int unsigned spill_count = 0;
  int unsigned query_count = 0;
  int unsigned error_count = 0;
  int unsigned send_gap;
  int unsigned recv_gap;
  logic        quiet;

  assign quiet = (pending_chars.size() < QUIET_TAIL);

  // Radix, digit count and opening letter of each numeric escape.
  function automatic logic [4:0] radix_of(esd_kind_e k);
    case (k)
      KIND_BIN: return 5'd2;
      KIND_OCT: return 5'd8;
      KIND_DEC: return 5'd10;
      default: return 5'd16;
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] need_of(esd_kind_e k);
    logic [CNT_W-1:0] n;
    case (k)
      KIND_BIN: n = 4'd8;
      KIND_OCT: n = 4'd3;
      KIND_DEC: n = 4'd3;
      KIND_HEX2: n = 4'd2;
      default: n = 4'd4;
    endcase
    if (n > ESC_DIGITS) n = CNT_W'(ESC_DIGITS);
    return n;
  endfunction

  function automatic logic [CHAR_W-1:0] letter_of(esd_kind_e k);
    case (k)
      KIND_BIN: return CH_LOW_B;
      KIND_OCT: return CH_LOW_O;
      KIND_DEC: return CH_LOW_D;
      KIND_HEX2: return CH_LOW_X;
      default: return CH_LOW_U;
    endcase
  endfunction

  // Digit weight of a character; letters are matched with bit 5 and the upper byte ignored.
  function automatic logic [7:0] digit_weight(logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] folded;
    folded = c & CASE_MASK;
    if (c >= CH_ZERO && c <= CH_NINE) return 8'(c - CH_ZERO);
    if (folded >= CH_UPPER_A && folded <= CH_UPPER_Z) return 8'(folded - CH_UPPER_A + 16'd10);
    return 8'hFF;
  endfunction

  // A character that reads as digit value v, in random case and sometimes with stray bits.
  function automatic logic [CHAR_W-1:0] digit_glyph(int unsigned v);
    logic [CHAR_W-1:0] upper;
    if (v < 10) return CH_ZERO + 16'(v);
    upper = CH_UPPER_A + 16'(v - 10);
    case ($urandom_range(0, 3))
      0, 1: return upper;
      2: return upper | 16'h0020;
      default: return upper | (16'($urandom) & 16'hFF20);
    endcase
  endfunction

  // Append one predicted character to the current burst.
  task automatic emit_char(input logic [CHAR_W-1:0] c);
    burst_chars.insert(burst_chars.size(), c);
  endtask

  // Append one character to the query being built.
  task automatic add_query_char(input logic [CHAR_W-1:0] c);
    query_buf.insert(query_buf.size(), c);
  endtask

  // Plain text handling; a backslash that does not end the query opens an escape.
  task automatic take_as_text(input logic [CHAR_W-1:0] c, input logic fin);
    if (c == CH_BSL && !fin) begin
      phase_q = PH_ESCAPE;
    end else begin
      phase_q = PH_TEXT;
      emit_char(c);
    end
  endtask

  // Give back the backslash, the letter and the digits taken so far.
  task automatic spill_escape();
    emit_char(CH_BSL);
    emit_char(letter_of(kind_q));
    for (int i = 0; i < int'(taken_q) && i < ESC_DIGITS; i++) begin
      emit_char(CHAR_W'(digits_q[i]));
    end
    phase_q = PH_TEXT;
    spill_count++;
  endtask

  // Predict the characters that one accepted input character causes.
  task automatic decode_char(input logic [CHAR_W-1:0] c, input logic fin);
    logic [7:0]       w;
    logic [4:0]       radix;
    logic [CNT_W-1:0] need;
    logic             opens;
    esd_kind_e        k;
    text_char_t       item;
    burst_chars.delete();
    case (phase_q)
      PH_ESCAPE: begin
        phase_q = PH_TEXT;
        opens = 1'b0;
        k = KIND_BIN;
        case (c)
          CH_LOW_N: emit_char(CH_LF);
          CH_LOW_T: emit_char(CH_TAB);
          CH_LOW_R: emit_char(CH_CR);
          CH_ZERO: emit_char(CH_NUL);
          CH_BSL: emit_char(CH_BSL);
          CH_LOW_B: begin
            opens = 1'b1;
            k = KIND_BIN;
          end
          CH_LOW_O: begin
            opens = 1'b1;
            k = KIND_OCT;
          end
          CH_LOW_D: begin
            opens = 1'b1;
            k = KIND_DEC;
          end
          CH_LOW_X: begin
            opens = 1'b1;
            k = KIND_HEX2;
          end
          CH_LOW_U: begin
            opens = 1'b1;
            k = KIND_HEX4;
          end
          default: begin
            emit_char(CH_BSL);
            emit_char(c);
          end
        endcase
        if (opens) begin
          kind_q = k;
          taken_q = '0;
          acc_q = '0;
          if (fin) spill_escape();
          else phase_q = PH_DIGITS;
        end
      end
      PH_DIGITS: begin
        radix = radix_of(kind_q);
        need = need_of(kind_q);
        w = digit_weight(c);
        if (w < 8'(radix) && taken_q < need) begin
          acc_q = 16'(32'(acc_q) * 32'(radix) + 32'(w));
          if (taken_q < ESC_DIGITS) digits_q[taken_q[DIG_IDX_W-1:0]] = c[SYM_W-1:0];
          taken_q = taken_q + 1'b1;
          if (taken_q >= need) begin
            emit_char(acc_q);
            phase_q = PH_TEXT;
          end else if (fin) begin
            spill_escape();
          end
        end else begin
          spill_escape();
          take_as_text(c, fin);
        end
      end
      default: take_as_text(c, fin);
    endcase
    foreach (burst_chars[i]) begin
      item.ch = burst_chars[i];
      item.fin = fin && (i == burst_chars.size() - 1);
      expected_chars.insert(expected_chars.size(), item);
    end
  endtask

  // Move the collected query into the pending queue, marking its last character.
  task automatic close_query();
    text_char_t item;
    foreach (query_buf[i]) begin
      item.ch = query_buf[i];
      item.fin = (i == query_buf.size() - 1);
      pending_chars.insert(pending_chars.size(), item);
    end
    query_buf.delete();
    query_count++;
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver: offers pending characters with random idle bursts.
  always @(posedge clk or negedge rst_n) begin : drive_chars
    text_char_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.char_in <= '0;
      in_if.is_final <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        decode_char(in_if.char_in, in_if.is_final);
        accepted_count++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_if.valid <= 1'b0;
        end else if (pending_chars.size() == 0) begin
          in_if.valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
          send_gap <= $urandom_range(0, 2);
          in_if.valid <= 1'b0;
        end else begin
          nxt = pending_chars.pop_front();
          in_if.valid <= 1'b1;
          in_if.char_in <= nxt.ch;
          in_if.is_final <= nxt.fin;
        end
      end
    end
  end

  // Monitor: checks each decoded character against the oldest prediction.
  always @(posedge clk or negedge rst_n) begin : check_chars
    text_char_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected output, expected nothing actual char %h final %b",
                   $time, out_if.char_out, out_if.is_final_out);
          error_count++;
        end else begin
          want = expected_chars.pop_front();
          checked_count++;
          if (out_if.char_out !== want.ch) begin
            $display("%0t: char_out mismatch, expected %h actual %h", $time, want.ch,
                     out_if.char_out);
            error_count++;
          end
          if (out_if.is_final_out !== want.fin) begin
            $display("%0t: is_final_out mismatch, expected %b actual %b", $time, want.fin,
                     out_if.is_final_out);
            error_count++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        recv_gap <= $urandom_range(0, 2);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin : run_test
    int unsigned       sel;
    int unsigned       ntok;
    int unsigned       need;
    int unsigned       cut;
    int unsigned       radix;
    esd_kind_e         kind;
    logic [CHAR_W-1:0] c;

    rst_n = 1'b0;

    // Directed part: extreme characters, every simple escape, an unknown escape,
    // a complete hex escape, fallbacks whose offending character is text or a new escape.
    query_buf = '{16'hFFFF, 16'h0000, CH_BSL, CH_LOW_N, CH_BSL, CH_LOW_T, CH_BSL, CH_LOW_R,
                  CH_BSL, CH_ZERO, CH_BSL, CH_BSL, CH_BSL, 16'h0071, CH_BSL, CH_LOW_X,
                  16'h0034, 16'h0066, CH_BSL, CH_LOW_X, 16'h0047, CH_BSL, CH_LOW_O, CH_BSL,
                  CH_LOW_N};
    close_query();
    // Trailing lone backslash.
    query_buf = '{CH_BSL};
    close_query();
    // Query ends on the letter of a numeric escape.
    query_buf = '{CH_BSL, CH_LOW_U};
    close_query();
    // Query ends on a digit that does not complete the escape.
    query_buf = '{CH_BSL, CH_LOW_D, 16'h0031};
    close_query();

    // Random part: queries of mostly well-formed escapes mixed with text and noise.
    while (pending_chars.size() < TOTAL_ITEMS) begin
      ntok = $urandom_range(1, 6);
      for (int t = 0; t < ntok; t++) begin
        sel = $urandom_range(0, 99);
        kind = esd_kind_e'($urandom_range(0, 4));
        radix = 32'(radix_of(kind));
        need = 32'(need_of(kind));
        if (sel < 25) begin
          if ($urandom_range(0, 1) == 0) add_query_char(16'($urandom));
          else add_query_char(16'($urandom_range(16'h20, 16'h7E)));
        end else if (sel < 40) begin
          add_query_char(CH_BSL);
          case ($urandom_range(0, 4))
            0: add_query_char(CH_LOW_N);
            1: add_query_char(CH_LOW_T);
            2: add_query_char(CH_LOW_R);
            3: add_query_char(CH_ZERO);
            default: add_query_char(CH_BSL);
          endcase
        end else if (sel < 75) begin
          add_query_char(CH_BSL);
          add_query_char(letter_of(kind));
          cut = need;
          if (t == ntok - 1 && $urandom_range(0, 3) == 0) cut = $urandom_range(0, need - 1);
          for (int j = 0; j < cut; j++) begin
            add_query_char(digit_glyph($urandom_range(0, radix - 1)));
          end
        end else if (sel < 88) begin
          add_query_char(CH_BSL);
          add_query_char(letter_of(kind));
          cut = $urandom_range(0, need - 1);
          for (int j = 0; j < cut; j++) begin
            add_query_char(digit_glyph($urandom_range(0, radix - 1)));
          end
          case ($urandom_range(0, 2))
            0: c = digit_glyph($urandom_range(radix, 35));
            1: c = 16'($urandom);
            default: c = CH_BSL;
          endcase
          add_query_char(c);
        end else if (sel < 95 || t != ntok - 1) begin
          add_query_char(CH_BSL);
          if ($urandom_range(0, 1) == 0) add_query_char(16'($urandom));
          else add_query_char(16'($urandom_range(16'h20, 16'h7E)));
        end else begin
          add_query_char(CH_BSL);
        end
      end
      close_query();
    end
    total_items = pending_chars.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (accepted_count < total_items || expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d characters in %0d queries; checked %0d decoded characters.",
             accepted_count, query_count, checked_count);
    $display("Escape fallbacks predicted: %0d; errors: %0d.", spill_count, error_count);
    if (error_count == 0 && expected_chars.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("Timeout with %0d characters still expected.", expected_chars.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
